// File: hdl/lpot_pkg.sv
`timescale 1ns / 1ps

package lpot_pkg;

	// Table geometry. The home slot is taken from the low key bits, so SLOTS
	// is kept a power of two.
	localparam int SLOTS  = 64;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int KEY_W  = 32;
	localparam int SLOT_W = 6;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_ZERO_KEY  = 2'd3
	} st_t;

	typedef struct packed {
		op_t              kind;
		logic [KEY_W-1:0] owner_key;
	} lpot_req_t;

	typedef struct packed {
		st_t               status;
		logic [SLOT_W-1:0] slot_index;
	} lpot_rsp_t;

	// Commands from the probe sequencer to the owner store.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [KEY_W-1:0] wr_data;
		logic             clr;
	} lpot_st_cmd_t;

endpackage

// File: hdl/lpot_store.sv
`timescale 1ns / 1ps

module lpot_store import lpot_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lpot_st_cmd_t     cmd,
	output logic [KEY_W-1:0] rd_data
);

	logic [KEY_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic [KEY_W-1:0] data_q;
	logic             dvld_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			data_q <= mem[cmd.rd_addr];
		end
	end

	// An entry never written since reset or the last clear reads as free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			dvld_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				vld_q <= '0;
			end else if (cmd.wr_en) begin
				vld_q[cmd.wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				dvld_q <= vld_q[cmd.rd_addr];
			end
		end
	end

	assign rd_data = dvld_q ? data_q : '0;

endmodule

// File: hdl/lpot_probe.sv
`timescale 1ns / 1ps

module lpot_probe import lpot_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  lpot_req_t        req,
	input  logic [KEY_W-1:0] rd_data,
	output logic             busy,
	output lpot_st_cmd_t     cmd,
	output logic             fin,
	output lpot_rsp_t        rsp
);

	typedef enum logic [0:0] {
		S_IDLE,
		S_PROBE
	} state_t;

	state_t           state_q;
	op_t              kind_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] want_q;
	logic [IDX_W-1:0] issue_addr_q;
	logic [CNT_W-1:0] issued_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_addr_s1;
	logic             chk_last_s1;

	logic             accept;
	logic             issuing;
	logic             hit;
	logic             miss;
	logic [IDX_W-1:0] next_addr;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign hit       = chk_vld_s1 && (rd_data == want_q);
	assign miss      = chk_vld_s1 && chk_last_s1 && !hit;
	assign issuing   = (state_q == S_PROBE) && (issued_q < CNT_W'(SLOTS)) && !hit;
	assign next_addr = (issue_addr_q == IDX_W'(SLOTS - 1)) ? '0 : issue_addr_q + 1'b1;

	always_comb begin
		cmd         = '0;
		cmd.rd_en   = issuing;
		cmd.rd_addr = issue_addr_q;
		cmd.wr_addr = chk_addr_s1;
		cmd.wr_data = (kind_q == OP_INSERT) ? key_q : '0;
		fin         = 1'b0;
		rsp.status     = ST_DONE;
		rsp.slot_index = '0;
		if (accept) begin
			if (req.kind == OP_CLEAR) begin
				cmd.clr = 1'b1;
				fin     = 1'b1;
			end else if (req.owner_key == '0) begin
				fin        = 1'b1;
				rsp.status = ST_ZERO_KEY;
			end
		end else if (state_q == S_PROBE) begin
			if (hit) begin
				fin            = 1'b1;
				rsp.slot_index = SLOT_W'(chk_addr_s1);
				cmd.wr_en      = (kind_q != OP_LOOKUP);
			end else if (miss) begin
				fin        = 1'b1;
				rsp.status = (kind_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= OP_LOOKUP;
			key_q        <= '0;
			want_q       <= '0;
			issue_addr_q <= '0;
			issued_q     <= '0;
			chk_vld_s1   <= 1'b0;
			chk_addr_s1  <= '0;
			chk_last_s1  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					chk_vld_s1 <= 1'b0;
					if (accept && req.kind != OP_CLEAR && req.owner_key != '0) begin
						state_q      <= S_PROBE;
						kind_q       <= req.kind;
						key_q        <= req.owner_key;
						want_q       <= (req.kind == OP_INSERT) ? '0 : req.owner_key;
						issue_addr_q <= req.owner_key[IDX_W-1:0];
						issued_q     <= '0;
					end
				end
				S_PROBE: begin
					chk_vld_s1  <= issuing;
					chk_addr_s1 <= issue_addr_q;
					chk_last_s1 <= (issued_q == CNT_W'(SLOTS - 1));
					if (issuing) begin
						issue_addr_q <= next_addr;
						issued_q     <= issued_q + 1'b1;
					end
					if (hit || miss) begin
						state_q    <= S_IDLE;
						chk_vld_s1 <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/linear_probe_owner_table_core.sv
`timescale 1ns / 1ps

// Owner table with open addressing and linear probing. A request is taken at
// a clock edge where start is high and busy is low; busy then stays high
// until the request is finished. Clear and any request with a zero key
// finish in the accept cycle. Lookup, insert and remove walk the table one
// slot per cycle from the home slot (the low key bits), through a single
// store read port whose data is registered, and stop at the first matching
// entry, or once every slot has been probed. The result shows up on
// result, flagged by done for exactly one cycle, in the cycle after the
// request finishes. There is no way to stall it, so the receiver must take
// it in that cycle. A new request may be issued while done is high. All
// entries are free after reset and after a clear, with no clearing pass.

module linear_probe_owner_table_core import lpot_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  lpot_req_t req,
	output logic      busy,
	output logic      done,
	output lpot_rsp_t result
);

	lpot_st_cmd_t     st_cmd;
	logic [KEY_W-1:0] st_rd_data;
	logic             fin;
	lpot_rsp_t        rsp;
	logic             done_q;
	lpot_rsp_t        result_q;

	// Probe sequencer: owns the walk and the compare unit.
	lpot_probe u_probe (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.rd_data (st_rd_data),
		.busy    (busy),
		.cmd     (st_cmd),
		.fin     (fin),
		.rsp     (rsp)
	);

	// Owner store: one write port, one registered read port, and per-slot
	// valid bits so reset and clear take effect at once.
	lpot_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (st_cmd),
		.rd_data (st_rd_data)
	);

	// The result register decouples the probe logic from the output pins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_q <= rsp;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A clear always finishes right away with a done status and slot zero.
	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.kind == OP_CLEAR
		|=> done && result.status == ST_DONE && result.slot_index == '0)
		else $error("clear request did not finish in one cycle");

	// A zero key is turned away at once for every other operation.
	a_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.kind != OP_CLEAR && req.owner_key == '0
		|=> done && result.status == ST_ZERO_KEY)
		else $error("zero key request not rejected");

	// A real probe keeps the block busy on the next cycle.
	a_probe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.kind != OP_CLEAR && req.owner_key != '0
		|=> busy && !done)
		else $error("probe request did not hold busy");

	// Failed requests report slot zero.
	a_fail_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_DONE |-> result.slot_index == '0)
		else $error("failed request reported a nonzero slot");

endmodule

// File: tb/tb_linear_probe_owner_table_core.sv
`timescale 1ns / 1ps

module tb_linear_probe_owner_table_core;
	import lpot_pkg::*;

	// The slowest request probes every slot, and its result is registered on the way out.
	localparam int DRAIN_CYCLES = SLOTS + 8;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int TARGET_REQS  = 500;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	lpot_req_t req    = '0;
	logic      busy;
	logic      done;
	lpot_rsp_t result;

	linear_probe_owner_table_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	// Requests waiting to go out, and the responses predicted for the
	// requests the table has already taken, oldest first.
	lpot_req_t pending_reqs[$];
	lpot_rsp_t expected_rsps[$];

	// Our own copy of the owner store, updated as each request is taken.
	logic [KEY_W-1:0] owner_model [SLOTS];

	int unsigned issued_cnt   = 0;
	int unsigned accepted_cnt = 0;
	int unsigned error_count  = 0;
	int unsigned cycle_cnt    = 0;
	int          burst_left   = 1;
	int          gap_left     = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		error_count++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// Works out the response to one request and applies its effect on the
	// owner store. The probe walks every slot once from the home slot, and it
	// does not stop at free entries, so a removed key never hides the keys
	// that were placed after it. An insert looks for a free entry (key 0).
	function automatic lpot_rsp_t predict_owner_op(input lpot_req_t r);
		lpot_rsp_t        rsp;
		logic [KEY_W-1:0] want;
		logic [IDX_W-1:0] idx;
		logic             hit;
		int               n;
		rsp.status     = ST_DONE;
		rsp.slot_index = '0;
		hit            = 1'b0;
		if (r.kind == OP_CLEAR) begin
			for (n = 0; n < SLOTS; n++)
				owner_model[n] = '0;
		end else if (r.owner_key == '0) begin
			rsp.status = ST_ZERO_KEY;
		end else begin
			want = (r.kind == OP_INSERT) ? '0 : r.owner_key;
			idx  = IDX_W'(r.owner_key % SLOTS);
			for (n = 0; n < SLOTS && !hit; n++) begin
				if (owner_model[idx] == want)
					hit = 1'b1;
				else
					idx = (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
			end
			if (hit) begin
				rsp.slot_index = SLOT_W'(idx);
				if (r.kind == OP_INSERT)
					owner_model[idx] = r.owner_key;
				else if (r.kind == OP_REMOVE)
					owner_model[idx] = '0;
			end else begin
				rsp.status = (r.kind == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
			end
		end
		return rsp;
	endfunction

	task automatic add_req(input op_t k, input logic [KEY_W-1:0] key);
		lpot_req_t r;
		r.kind      = k;
		r.owner_key = key;
		pending_reqs.push_back(r);
	endtask

	// A nonzero key. When clustered, the home slot falls into a narrow band
	// near the top of the table so that probes pile up and wrap around.
	function automatic logic [KEY_W-1:0] pick_key(input logic clustered);
		logic [KEY_W-1:0] key;
		key = $urandom;
		if (clustered)
			key[IDX_W-1:0] = IDX_W'($urandom_range(SLOTS - 4, SLOTS - 1));
		if (key == '0)
			key = 32'h8000_0000;
		return key;
	endfunction

	// Fills the request queue: a short directed run first, then random
	// episodes. Each episode works on a small pool of keys, so that lookups
	// and removes mostly hit and inserts often repeat a key. Fill episodes
	// lean hard on inserts so that the table runs full.
	task automatic build_requests();
		logic [KEY_W-1:0] pool [16];
		int               ep;
		int               ep_len;
		int               ins_pct;
		int               i;
		int               r;
		logic             clustered;

		// A zero key is rejected by every operation except clear.
		add_req(OP_LOOKUP, '0);
		add_req(OP_INSERT, '0);
		add_req(OP_REMOVE, '0);
		// Missing keys in an empty table.
		add_req(OP_LOOKUP, 32'h0000_0005);
		add_req(OP_REMOVE, 32'h0000_0005);
		// Home slot at the top of the table, then a collision that wraps to
		// slot 0, then a duplicate of the first key that goes further on.
		add_req(OP_INSERT, 32'hFFFF_FFFF);
		add_req(OP_INSERT, 32'h0000_003F);
		add_req(OP_INSERT, 32'hFFFF_FFFF);
		add_req(OP_LOOKUP, 32'hFFFF_FFFF);
		// After the first copy is removed, the walk passes the freed home
		// slot and finds the duplicate.
		add_req(OP_REMOVE, 32'hFFFF_FFFF);
		add_req(OP_LOOKUP, 32'hFFFF_FFFF);
		add_req(OP_LOOKUP, 32'h0000_003F);
		add_req(OP_INSERT, 32'h8000_0000);
		add_req(OP_LOOKUP, 32'h8000_0000);
		// Clear ignores its key, and every entry is free afterwards.
		add_req(OP_CLEAR, 32'hDEAD_BEEF);
		add_req(OP_LOOKUP, 32'h0000_003F);
		add_req(OP_LOOKUP, 32'hFFFF_FFFF);
		add_req(OP_INSERT, 32'h0000_0001);
		add_req(OP_REMOVE, 32'h0000_0001);
		add_req(OP_CLEAR, '0);

		ep = 0;
		while (pending_reqs.size() < TARGET_REQS) begin
			clustered = ($urandom_range(0, 1) == 1);
			for (i = 0; i < 16; i++)
				pool[i] = pick_key(clustered);
			// The first episode is always a fill episode.
			case ((ep == 0) ? 0 : $urandom_range(0, 2))
				0: begin
					ins_pct = 85;
					ep_len  = $urandom_range(80, 110);
				end
				1: begin
					ins_pct = 45;
					ep_len  = $urandom_range(40, 80);
				end
				default: begin
					ins_pct = 20;
					ep_len  = $urandom_range(30, 60);
				end
			endcase
			if (ep != 0 && $urandom_range(0, 1) == 1)
				add_req(OP_CLEAR, $urandom);
			for (i = 0; i < ep_len; i++) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					add_req(OP_CLEAR, $urandom);
				else if (r < 5)
					add_req(op_t'($urandom_range(0, 2)), '0);
				else if (r < 5 + ins_pct)
					add_req(OP_INSERT, ($urandom_range(0, 9) < 7) ?
						pool[$urandom_range(0, 15)] : pick_key(clustered));
				else
					add_req(($urandom_range(0, 1) == 1) ? OP_REMOVE : OP_LOOKUP,
						($urandom_range(0, 9) < 8) ?
						pool[$urandom_range(0, 15)] : pick_key(clustered));
			end
			ep++;
		end
	endtask

	// Driver. A request is held on the inputs until the table takes it. The
	// sender works in bursts of random length; between bursts it holds back
	// for a random number of cycles, which lands the next start at varying
	// points of the probe walk. A gap of zero gives back-to-back stretches.
	always @(negedge clk) begin
		if (arst_n && accepted_cnt == issued_cnt) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start    <= 1'b0;
			end else if (pending_reqs.size() == 0) begin
				start <= 1'b0;
			end else begin
				start      <= 1'b1;
				req        <= pending_reqs.pop_front();
				issued_cnt <= issued_cnt + 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Monitor. A response seen at this edge belongs to an earlier request, so
	// it is checked before a request taken at the same edge is predicted.
	always @(posedge clk) begin
		lpot_rsp_t exp_rsp;
		if (arst_n) begin
			if (done) begin
				if (expected_rsps.size() == 0) begin
					flag_mismatch($sformatf("response with no request outstanding: %p",
						result));
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (result.status !== exp_rsp.status)
						flag_mismatch($sformatf("status got %0d want %0d",
							result.status, exp_rsp.status));
					if (result.slot_index !== exp_rsp.slot_index)
						flag_mismatch($sformatf("slot_index got %0d want %0d",
							result.slot_index, exp_rsp.slot_index));
				end
			end
			if (start && !busy) begin
				expected_rsps.push_back(predict_owner_op(req));
				accepted_cnt <= accepted_cnt + 1;
			end
		end
	end

	// Watchdog for a hung handshake or a response that never comes.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		for (int n = 0; n < SLOTS; n++)
			owner_model[n] = '0;
		build_requests();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait until every request has gone out and every response is back,
		// then idle a little longer to catch a stray strobe.
		while (pending_reqs.size() != 0 || accepted_cnt != issued_cnt ||
			expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_rsps.size() != 0)
			flag_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));

		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: linear_probe_owner_table_core.f
hdl/lpot_pkg.sv
hdl/lpot_store.sv
hdl/lpot_probe.sv
hdl/linear_probe_owner_table_core.sv
tb/tb_linear_probe_owner_table_core.sv
